[rtl/cabo_pkg.sv]
// ----------------------------------------------------------------------------
// cabo_pkg
// Shared types and codes for the flag-producing ALU and bit-op block.
// ----------------------------------------------------------------------------
package cabo_pkg;

    localparam logic [5:0] OP_ADD   = 6'd0;
    localparam logic [5:0] OP_ADC   = 6'd1;
    localparam logic [5:0] OP_SUB   = 6'd2;
    localparam logic [5:0] OP_SBC   = 6'd3;
    localparam logic [5:0] OP_AND   = 6'd4;
    localparam logic [5:0] OP_XOR   = 6'd5;
    localparam logic [5:0] OP_OR    = 6'd6;
    localparam logic [5:0] OP_CP    = 6'd7;
    localparam logic [5:0] OP_INC8  = 6'd8;
    localparam logic [5:0] OP_DEC8  = 6'd9;
    localparam logic [5:0] OP_ADD16 = 6'd10;
    localparam logic [5:0] OP_ADDSP = 6'd11;
    localparam logic [5:0] OP_DAA   = 6'd12;
    localparam logic [5:0] OP_CPL   = 6'd13;
    localparam logic [5:0] OP_SCF   = 6'd14;
    localparam logic [5:0] OP_CCF   = 6'd15;
    localparam logic [5:0] OP_RLCA  = 6'd16;
    localparam logic [5:0] OP_RRCA  = 6'd17;
    localparam logic [5:0] OP_RLA   = 6'd18;
    localparam logic [5:0] OP_RRA   = 6'd19;
    localparam logic [5:0] OP_RLC   = 6'd20;
    localparam logic [5:0] OP_RRC   = 6'd21;
    localparam logic [5:0] OP_RL    = 6'd22;
    localparam logic [5:0] OP_RR    = 6'd23;
    localparam logic [5:0] OP_SLA   = 6'd24;
    localparam logic [5:0] OP_SRA   = 6'd25;
    localparam logic [5:0] OP_SWAP  = 6'd26;
    localparam logic [5:0] OP_SRL   = 6'd27;
    localparam logic [5:0] OP_BIT   = 6'd28;
    localparam logic [5:0] OP_RES   = 6'd29;
    localparam logic [5:0] OP_SET   = 6'd30;
    localparam logic [5:0] OP_INC16 = 6'd31;
    localparam logic [5:0] OP_DEC16 = 6'd32;

    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    localparam logic [7:0] DAA_LIMIT = 8'h99;
    localparam logic [3:0] DAA_NIB   = 4'h9;
    localparam logic [7:0] DAA_LO    = 8'h06;
    localparam logic [7:0] DAA_HI    = 8'h60;

    typedef struct packed {
        logic [5:0]  op;
        logic [15:0] first_operand;
        logic [15:0] second_operand;
        logic [2:0]  bit_index;
        logic [3:0]  flags_in;
    } t_item;

    typedef struct packed {
        logic [15:0] result;
        logic [3:0]  flags_out;
        logic        write_result;
    } t_result;

endpackage

[rtl/cpu_alu_and_bit_ops.sv]
// ----------------------------------------------------------------------------
// cpu_alu_and_bit_ops
// Flag-producing 8/16-bit ALU with prefixed rotate, shift and bit operations.
// ----------------------------------------------------------------------------
// Takes one operation per clock while not stalled. An accepted operation is held in
// the input register, passes through all ALU logic and is captured in the result
// register. Throughput is one operation per cycle as long as
// the consumer does not stall; o_stall follows i_stall combinationally only
// when both registers hold an item. Results come out in order, one per input.
// ----------------------------------------------------------------------------
module cpu_alu_and_bit_ops (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [5:0]  i_op,
    input  logic [15:0] i_first_operand,
    input  logic [15:0] i_second_operand,
    input  logic [2:0]  i_bit_index,
    input  logic [3:0]  i_flags_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_result,
    output logic [3:0]  o_flags_out,
    output logic        o_write_result
);
    import cabo_pkg::*;

    t_item   in_item;
    t_item   reg_item;
    t_result core_result;
    t_result out_result;
    logic    reg_valid;
    logic    adv;

    assign in_item.op             = i_op;
    assign in_item.first_operand  = i_first_operand;
    assign in_item.second_operand = i_second_operand;
    assign in_item.bit_index      = i_bit_index;
    assign in_item.flags_in       = i_flags_in;

    cabo_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (in_item),
        .i_adv   (adv),
        .o_valid (reg_valid),
        .o_item  (reg_item)
    );

    cabo_core u_core (
        .i_item   (reg_item),
        .o_result (core_result)
    );

    cabo_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (reg_valid),
        .i_result (core_result),
        .o_adv    (adv),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (out_result)
    );

    assign o_result       = out_result.result;
    assign o_flags_out    = out_result.flags_out;
    assign o_write_result = out_result.write_result;

endmodule

[rtl/cabo_in_stage.sv]
// ----------------------------------------------------------------------------
// cabo_in_stage
// Input register: captures one operation per transfer, holds it while the
// result side is stalled.
// ----------------------------------------------------------------------------
module cabo_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  cabo_pkg::t_item i_item,
    input  logic            i_adv,
    output logic            o_valid,
    output cabo_pkg::t_item o_item
);
    import cabo_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    logic  load;

    assign load    = !r_valid || i_adv;
    assign n_valid = load ? i_valid : r_valid;
    assign o_stall = !load;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

[rtl/cabo_core.sv]
// ----------------------------------------------------------------------------
// cabo_core
// Combinational ALU: arithmetic, logic, decimal adjust, rotates, shifts and
// single-bit operations with Z N H C flag generation.
// ----------------------------------------------------------------------------
module cabo_core (
    input  cabo_pkg::t_item   i_item,
    output cabo_pkg::t_result o_result
);
    import cabo_pkg::*;

    logic [7:0]  a;
    logic [7:0]  d;
    logic [15:0] a16;
    logic [15:0] d16;
    logic        zi;
    logic        ni;
    logic        hi;
    logic        ci;
    logic        cin;
    logic [8:0]  sum8;
    logic [4:0]  hsum8;
    logic [8:0]  dif8;
    logic [4:0]  hdif8;
    logic [16:0] sum16;
    logic [12:0] hsum16;
    logic [15:0] sum_sp;
    logic [4:0]  hsum_sp;
    logic [8:0]  csum_sp;
    logic [7:0]  daa_adj;
    logic        daa_c;
    logic [7:0]  bit_mask;
    logic [15:0] res;
    logic [3:0]  fo;
    logic        wr;

    assign a   = i_item.first_operand[7:0];
    assign d   = i_item.second_operand[7:0];
    assign a16 = i_item.first_operand;
    assign d16 = i_item.second_operand;
    assign zi  = i_item.flags_in[FLAG_Z];
    assign ni  = i_item.flags_in[FLAG_N];
    assign hi  = i_item.flags_in[FLAG_H];
    assign ci  = i_item.flags_in[FLAG_C];

    assign cin = ci && (i_item.op == OP_ADC || i_item.op == OP_SBC);

    assign sum8    = {1'b0, a} + {1'b0, d} + {8'd0, cin};
    assign hsum8   = {1'b0, a[3:0]} + {1'b0, d[3:0]} + {4'd0, cin};
    assign dif8    = {1'b0, a} - {1'b0, d} - {8'd0, cin};
    assign hdif8   = {1'b0, a[3:0]} - {1'b0, d[3:0]} - {4'd0, cin};
    assign sum16   = {1'b0, a16} + {1'b0, d16};
    assign hsum16  = {1'b0, a16[11:0]} + {1'b0, d16[11:0]};
    assign sum_sp  = a16 + {{8{d[7]}}, d};
    assign hsum_sp = {1'b0, a16[3:0]} + {1'b0, d[3:0]};
    assign csum_sp = {1'b0, a16[7:0]} + {1'b0, d};
    assign bit_mask = 8'(1) << i_item.bit_index;

    always_comb begin
        daa_adj = 8'd0;
        daa_c   = ci;
        if (hi || (!ni && a[3:0] > DAA_NIB)) begin
            daa_adj = DAA_LO;
        end
        if (ci || (!ni && a > DAA_LIMIT)) begin
            daa_adj = daa_adj | DAA_HI;
            daa_c   = 1'b1;
        end
    end

    always_comb begin
        res = 16'd0;
        fo  = i_item.flags_in;
        wr  = 1'b1;
        case (i_item.op)
            OP_ADD, OP_ADC: begin
                res = {8'd0, sum8[7:0]};
                fo  = {sum8[7:0] == 8'd0, 1'b0, hsum8[4], sum8[8]};
            end
            OP_SUB, OP_SBC, OP_CP: begin
                fo = {dif8[7:0] == 8'd0, 1'b1, hdif8[4], dif8[8]};
                if (i_item.op == OP_CP) begin
                    wr = 1'b0;
                end else begin
                    res = {8'd0, dif8[7:0]};
                end
            end
            OP_AND: begin
                res = {8'd0, a & d};
                fo  = {(a & d) == 8'd0, 1'b0, 1'b1, 1'b0};
            end
            OP_XOR: begin
                res = {8'd0, a ^ d};
                fo  = {(a ^ d) == 8'd0, 3'b000};
            end
            OP_OR: begin
                res = {8'd0, a | d};
                fo  = {(a | d) == 8'd0, 3'b000};
            end
            OP_INC8: begin
                res = {8'd0, a + 8'd1};
                fo  = {a == 8'hff, 1'b0, a[3:0] == 4'hf, ci};
            end
            OP_DEC8: begin
                res = {8'd0, a - 8'd1};
                fo  = {a == 8'h01, 1'b1, a[3:0] == 4'h0, ci};
            end
            OP_ADD16: begin
                res = sum16[15:0];
                fo  = {zi, 1'b0, hsum16[12], sum16[16]};
            end
            OP_ADDSP: begin
                res = sum_sp;
                fo  = {2'b00, hsum_sp[4], csum_sp[8]};
            end
            OP_DAA: begin
                res = {8'd0, ni ? (a - daa_adj) : (a + daa_adj)};
                fo  = {res[7:0] == 8'd0, ni, 1'b0, daa_c};
            end
            OP_CPL: begin
                res = {8'd0, ~a};
                fo  = {zi, 1'b1, 1'b1, ci};
            end
            OP_SCF: begin
                wr = 1'b0;
                fo = {zi, 1'b0, 1'b0, 1'b1};
            end
            OP_CCF: begin
                wr = 1'b0;
                fo = {zi, 1'b0, 1'b0, !ci};
            end
            OP_RLCA: begin
                res = {8'd0, a[6:0], a[7]};
                fo  = {3'b000, a[7]};
            end
            OP_RRCA: begin
                res = {8'd0, a[0], a[7:1]};
                fo  = {3'b000, a[0]};
            end
            OP_RLA: begin
                res = {8'd0, a[6:0], ci};
                fo  = {3'b000, a[7]};
            end
            OP_RRA: begin
                res = {8'd0, ci, a[7:1]};
                fo  = {3'b000, a[0]};
            end
            OP_RLC: begin
                res = {8'd0, a[6:0], a[7]};
                fo  = {res[7:0] == 8'd0, 2'b00, a[7]};
            end
            OP_RL: begin
                res = {8'd0, a[6:0], ci};
                fo  = {res[7:0] == 8'd0, 2'b00, a[7]};
            end
            OP_SLA: begin
                res = {8'd0, a[6:0], 1'b0};
                fo  = {res[7:0] == 8'd0, 2'b00, a[7]};
            end
            OP_RRC: begin
                res = {8'd0, a[0], a[7:1]};
                fo  = {res[7:0] == 8'd0, 2'b00, a[0]};
            end
            OP_RR: begin
                res = {8'd0, ci, a[7:1]};
                fo  = {res[7:0] == 8'd0, 2'b00, a[0]};
            end
            OP_SRA: begin
                res = {8'd0, a[7], a[7:1]};
                fo  = {res[7:0] == 8'd0, 2'b00, a[0]};
            end
            OP_SRL: begin
                res = {8'd0, 1'b0, a[7:1]};
                fo  = {res[7:0] == 8'd0, 2'b00, a[0]};
            end
            OP_SWAP: begin
                res = {8'd0, a[3:0], a[7:4]};
                fo  = {a == 8'd0, 3'b000};
            end
            OP_BIT: begin
                wr = 1'b0;
                fo = {(a & bit_mask) == 8'd0, 1'b0, 1'b1, ci};
            end
            OP_RES: begin
                res = {8'd0, a & ~bit_mask};
            end
            OP_SET: begin
                res = {8'd0, a | bit_mask};
            end
            OP_INC16: begin
                res = a16 + 16'd1;
            end
            OP_DEC16: begin
                res = a16 - 16'd1;
            end
            default: begin
                wr = 1'b0;
            end
        endcase
    end

    assign o_result.result       = res;
    assign o_result.flags_out    = fo;
    assign o_result.write_result = wr;

endmodule

[rtl/cabo_out_stage.sv]
// ----------------------------------------------------------------------------
// cabo_out_stage
// Result register: holds a finished result until the consumer takes it.
// ----------------------------------------------------------------------------
module cabo_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  cabo_pkg::t_result i_result,
    output logic              o_adv,
    output logic              o_valid,
    input  logic              i_stall,
    output cabo_pkg::t_result o_result
);
    import cabo_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    assign o_adv    = !r_valid || !i_stall;
    assign n_valid  = o_adv ? i_valid : r_valid;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && i_valid) begin
            r_result <= i_result;
        end
    end

endmodule

[tb/tb_cpu_alu_and_bit_ops.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cpu_alu_and_bit_ops
// Self-checking testbench for the flag-producing ALU and bit-op block.
// ----------------------------------------------------------------------------
// Every input transfer is predicted in the testbench and the predicted result
// is queued in order. Every output transfer is compared field by field with
// the oldest queued prediction. A directed sweep of all op codes and flag
// corner cases comes first. Four random phases follow: free-running, sender
// gaps, receiver stalls, and both at once. The queue drains between phases.
// ----------------------------------------------------------------------------
module tb_cpu_alu_and_bit_ops;
    import cabo_pkg::*;

    localparam logic [5:0] OP_UNUSED_LO = 6'd33;
    localparam logic [5:0] OP_UNUSED_HI = 6'd63;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int          TAIL_CYCLES  = 8;
    localparam int          RANDOM_OPS   = 300;

    typedef struct packed {
        t_item   op_in;
        t_result want;
    } t_pending;

    class alu_scoreboard;
        t_pending    outstanding[$];
        int unsigned errors;
        int unsigned compared;

        function t_result alu_outcome(t_item it);
            logic [7:0]  a, d, r8, adj;
            logic [15:0] a16, d16, res;
            logic [8:0]  s9;
            logic [4:0]  s5;
            logic [12:0] s13;
            logic [16:0] s17;
            logic        zi, ni, hi, ci, cy, narrow;
            logic [3:0]  f;
            t_result     r;
            a16 = it.first_operand;
            d16 = it.second_operand;
            a = a16[7:0];
            d = d16[7:0];
            zi = it.flags_in[FLAG_Z];
            ni = it.flags_in[FLAG_N];
            hi = it.flags_in[FLAG_H];
            ci = it.flags_in[FLAG_C];
            f = it.flags_in;
            res = '0;
            r8 = '0;
            narrow = 1'b1;
            r.write_result = 1'b1;
            case (it.op)
                OP_ADD, OP_ADC: begin
                    cy = (it.op == OP_ADC) && ci;
                    s9 = {1'b0, a} + {1'b0, d} + 9'(cy);
                    s5 = {1'b0, a[3:0]} + {1'b0, d[3:0]} + 5'(cy);
                    r8 = s9[7:0];
                    f = {r8 == 8'h00, 1'b0, s5[4], s9[8]};
                end
                OP_SUB, OP_SBC, OP_CP: begin
                    cy = (it.op == OP_SBC) && ci;
                    s9 = {1'b0, a} - {1'b0, d} - 9'(cy);
                    s5 = {1'b0, a[3:0]} - {1'b0, d[3:0]} - 5'(cy);
                    r8 = s9[7:0];
                    f = {r8 == 8'h00, 1'b1, s5[4], s9[8]};
                    if (it.op == OP_CP) begin
                        r8 = 8'h00;
                        r.write_result = 1'b0;
                    end
                end
                OP_AND: begin
                    r8 = a & d;
                    f = {r8 == 8'h00, 1'b0, 1'b1, 1'b0};
                end
                OP_XOR: begin
                    r8 = a ^ d;
                    f = {r8 == 8'h00, 3'b000};
                end
                OP_OR: begin
                    r8 = a | d;
                    f = {r8 == 8'h00, 3'b000};
                end
                OP_INC8: begin
                    r8 = a + 8'd1;
                    f = {r8 == 8'h00, 1'b0, a[3:0] == 4'hF, ci};
                end
                OP_DEC8: begin
                    r8 = a - 8'd1;
                    f = {r8 == 8'h00, 1'b1, a[3:0] == 4'h0, ci};
                end
                OP_ADD16: begin
                    narrow = 1'b0;
                    s17 = {1'b0, a16} + {1'b0, d16};
                    s13 = {1'b0, a16[11:0]} + {1'b0, d16[11:0]};
                    res = s17[15:0];
                    f = {zi, 1'b0, s13[12], s17[16]};
                end
                OP_ADDSP: begin
                    narrow = 1'b0;
                    res = a16 + {{8{d[7]}}, d};
                    s5 = {1'b0, a16[3:0]} + {1'b0, d[3:0]};
                    s9 = {1'b0, a16[7:0]} + {1'b0, d};
                    f = {2'b00, s5[4], s9[8]};
                end
                OP_DAA: begin
                    adj = 8'h00;
                    cy = ci;
                    if (hi || (!ni && a[3:0] > 4'h9)) adj = 8'h06;
                    if (ci || (!ni && a > 8'h99)) begin
                        adj = adj | 8'h60;
                        cy = 1'b1;
                    end
                    r8 = ni ? a - adj : a + adj;
                    f = {r8 == 8'h00, ni, 1'b0, cy};
                end
                OP_CPL: begin
                    r8 = ~a;
                    f = {zi, 1'b1, 1'b1, ci};
                end
                OP_SCF: begin
                    r.write_result = 1'b0;
                    f = {zi, 1'b0, 1'b0, 1'b1};
                end
                OP_CCF: begin
                    r.write_result = 1'b0;
                    f = {zi, 1'b0, 1'b0, ~ci};
                end
                OP_RLCA: begin
                    r8 = {a[6:0], a[7]};
                    f = {3'b000, a[7]};
                end
                OP_RRCA: begin
                    r8 = {a[0], a[7:1]};
                    f = {3'b000, a[0]};
                end
                OP_RLA: begin
                    r8 = {a[6:0], ci};
                    f = {3'b000, a[7]};
                end
                OP_RRA: begin
                    r8 = {ci, a[7:1]};
                    f = {3'b000, a[0]};
                end
                OP_RLC, OP_RL, OP_SLA: begin
                    cy = (it.op == OP_RLC) ? a[7] : (it.op == OP_RL) ? ci : 1'b0;
                    r8 = {a[6:0], cy};
                    f = {r8 == 8'h00, 2'b00, a[7]};
                end
                OP_RRC, OP_RR, OP_SRA, OP_SRL: begin
                    cy = (it.op == OP_RRC) ? a[0] : (it.op == OP_RR) ? ci :
                         (it.op == OP_SRA) ? a[7] : 1'b0;
                    r8 = {cy, a[7:1]};
                    f = {r8 == 8'h00, 2'b00, a[0]};
                end
                OP_SWAP: begin
                    r8 = {a[3:0], a[7:4]};
                    f = {r8 == 8'h00, 3'b000};
                end
                OP_BIT: begin
                    r.write_result = 1'b0;
                    f = {~a[it.bit_index], 1'b0, 1'b1, ci};
                end
                OP_RES: r8 = a & ~(8'h01 << it.bit_index);
                OP_SET: r8 = a | (8'h01 << it.bit_index);
                OP_INC16: begin
                    narrow = 1'b0;
                    res = a16 + 16'd1;
                end
                OP_DEC16: begin
                    narrow = 1'b0;
                    res = a16 - 16'd1;
                end
                default: begin
                    narrow = 1'b0;
                    r.write_result = 1'b0;
                end
            endcase
            if (narrow) res = {8'h00, r8};
            r.result = res;
            r.flags_out = f;
            return r;
        endfunction

        function void note_transfer(t_item it);
            t_pending p;
            p.op_in = it;
            p.want = alu_outcome(it);
            outstanding.push_back(p);
        endfunction

        function int unsigned pending();
            return outstanding.size();
        endfunction

        task report_error(string what);
            $display("ERROR: %s", what);
            errors++;
        endtask

        task check_result(t_result got);
            t_pending p;
            if (outstanding.size() == 0) begin
                report_error($sformatf("unexpected result %h flags %h wr %b",
                                       got.result, got.flags_out, got.write_result));
                return;
            end
            p = outstanding.pop_front();
            compared++;
            if (got.result !== p.want.result)
                report_error($sformatf("op %0d a=%h d=%h b=%0d f=%h: result %h, want %h",
                    p.op_in.op, p.op_in.first_operand, p.op_in.second_operand,
                    p.op_in.bit_index, p.op_in.flags_in, got.result, p.want.result));
            if (got.flags_out !== p.want.flags_out)
                report_error($sformatf("op %0d a=%h d=%h b=%0d f=%h: flags %h, want %h",
                    p.op_in.op, p.op_in.first_operand, p.op_in.second_operand,
                    p.op_in.bit_index, p.op_in.flags_in, got.flags_out, p.want.flags_out));
            if (got.write_result !== p.want.write_result)
                report_error($sformatf("op %0d a=%h d=%h: write %b, want %b",
                    p.op_in.op, p.op_in.first_operand, p.op_in.second_operand,
                    got.write_result, p.want.write_result));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [5:0]  i_op = '0;
    logic [15:0] i_first_operand = '0;
    logic [15:0] i_second_operand = '0;
    logic [2:0]  i_bit_index = '0;
    logic [3:0]  i_flags_in = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [15:0] o_result;
    logic [3:0]  o_flags_out;
    logic        o_write_result;

    alu_scoreboard sb = new;
    int unsigned   cycle_count = 0;
    int unsigned   sent_count = 0;
    int unsigned   send_idle_pct = 0;
    int unsigned   stall_pct = 0;

    cpu_alu_and_bit_ops DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_op             (i_op),
        .i_first_operand  (i_first_operand),
        .i_second_operand (i_second_operand),
        .i_bit_index      (i_bit_index),
        .i_flags_in       (i_flags_in),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_result         (o_result),
        .o_flags_out      (o_flags_out),
        .o_write_result   (o_write_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ERROR: timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending());
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        t_item   it;
        t_result got;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                it.op = i_op;
                it.first_operand = i_first_operand;
                it.second_operand = i_second_operand;
                it.bit_index = i_bit_index;
                it.flags_in = i_flags_in;
                sb.note_transfer(it);
            end
            if (o_valid && !i_stall) begin
                got.result = o_result;
                got.flags_out = o_flags_out;
                got.write_result = o_write_result;
                sb.check_result(got);
            end
        end
    end

    task automatic send_op(input logic [5:0] op, input logic [15:0] a, input logic [15:0] d,
                           input logic [2:0] bi, input logic [3:0] fl);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op <= op;
        i_first_operand <= a;
        i_second_operand <= d;
        i_bit_index <= bi;
        i_flags_in <= fl;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sent_count++;
    endtask

    task automatic hold_until_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [5:0] pick_op();
        if ($urandom_range(15) == 0)
            return 6'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
        return 6'($urandom_range(OP_DEC16));
    endfunction

    function automatic logic [15:0] pick_operand();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h00FF;
            3: return {8'($urandom), 4'($urandom_range(9)), 4'($urandom_range(9))};
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic run_phase(input int unsigned idle, input int unsigned stall);
        send_idle_pct = idle;
        stall_pct = stall;
        for (int n = 0; n < RANDOM_OPS; n++)
            send_op(pick_op(), pick_operand(), pick_operand(), 3'($urandom), 4'($urandom));
        hold_until_drained();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed sweep: upper operand bits set on 8-bit ops, flag corners
        send_op(OP_ADD,   16'hAB0F, 16'hCD01, 3'd0, 4'h0);
        send_op(OP_ADC,   16'h00FF, 16'h00FF, 3'd7, 4'hF);
        send_op(OP_SUB,   16'h0000, 16'h0001, 3'd0, 4'h0);
        send_op(OP_SBC,   16'hFF10, 16'h000F, 3'd0, 4'h1);
        send_op(OP_AND,   16'h00F0, 16'h000F, 3'd0, 4'hF);
        send_op(OP_XOR,   16'hFFFF, 16'hFFFF, 3'd0, 4'h0);
        send_op(OP_OR,    16'h0000, 16'h0000, 3'd0, 4'hF);
        send_op(OP_CP,    16'h0042, 16'hFF42, 3'd0, 4'h0);
        send_op(OP_INC8,  16'h00FF, 16'h0000, 3'd0, 4'h1);
        send_op(OP_DEC8,  16'h0010, 16'h0000, 3'd0, 4'hE);
        send_op(OP_ADD16, 16'h0FFF, 16'h0001, 3'd0, 4'h8);
        send_op(OP_ADD16, 16'hFFFF, 16'hFFFF, 3'd0, 4'h0);
        send_op(OP_ADDSP, 16'hFFF8, 16'h0008, 3'd0, 4'hF);
        send_op(OP_ADDSP, 16'h0000, 16'hFF80, 3'd0, 4'h0);
        send_op(OP_DAA,   16'h009A, 16'h0000, 3'd0, 4'h0);
        send_op(OP_DAA,   16'h0000, 16'h0000, 3'd0, 4'h7);
        send_op(OP_CPL,   16'h0000, 16'h0000, 3'd0, 4'h0);
        send_op(OP_SCF,   16'h1234, 16'h5678, 3'd0, 4'h0);
        send_op(OP_CCF,   16'h1234, 16'h5678, 3'd0, 4'hF);
        send_op(OP_RLCA,  16'h0080, 16'h0000, 3'd0, 4'hF);
        send_op(OP_RRCA,  16'h0001, 16'h0000, 3'd0, 4'h0);
        send_op(OP_RLA,   16'h0080, 16'h0000, 3'd0, 4'h1);
        send_op(OP_RRA,   16'h0001, 16'h0000, 3'd0, 4'h1);
        send_op(OP_RLC,   16'hFF00, 16'h0000, 3'd0, 4'h0);
        send_op(OP_RRC,   16'h0001, 16'h0000, 3'd0, 4'h0);
        send_op(OP_RL,    16'h0080, 16'h0000, 3'd0, 4'h0);
        send_op(OP_RR,    16'h0001, 16'h0000, 3'd0, 4'h0);
        send_op(OP_SLA,   16'h0080, 16'h0000, 3'd0, 4'h1);
        send_op(OP_SRA,   16'h0081, 16'h0000, 3'd0, 4'h0);
        send_op(OP_SWAP,  16'h00F0, 16'h0000, 3'd0, 4'hF);
        send_op(OP_SRL,   16'h0001, 16'h0000, 3'd0, 4'h0);
        send_op(OP_BIT,   16'h007F, 16'h0000, 3'd7, 4'h0);
        send_op(OP_RES,   16'h00FF, 16'h0000, 3'd0, 4'h5);
        send_op(OP_SET,   16'h0000, 16'h0000, 3'd7, 4'hA);
        send_op(OP_INC16, 16'hFFFF, 16'h0000, 3'd0, 4'h3);
        send_op(OP_DEC16, 16'h0000, 16'h0000, 3'd0, 4'hC);
        send_op(OP_UNUSED_LO, 16'hFFFF, 16'hFFFF, 3'd7, 4'h9);
        send_op(OP_UNUSED_HI, 16'h5555, 16'hAAAA, 3'd3, 4'h6);
        hold_until_drained();

        run_phase(0, 0);
        run_phase(58, 0);
        run_phase(0, 58);
        run_phase(16, 16);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Summary: %0d operations sent, %0d results compared, %0d errors.",
                 sent_count, sb.compared, sb.errors);
        $display("Traffic: free-running, sender gaps, receiver stalls, and both combined.");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
